@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define ASSERT_CLK_ANY(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/amsp_pkg.sv @@
`default_nettype none
package amsp_pkg;

   localparam int MAX_PROCESSORS_DEFAULT = 256;
   localparam int POSITION_BITS_DEFAULT  = 16;

   localparam int COUNT_BITS = 9;
   localparam logic [COUNT_BITS-1:0] COUNT_SAT = 9'h100;

   localparam int HEADER_BYTES = 44;

   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

   localparam logic [7:0] ENTRY_PROCESSOR  = 8'd0;
   localparam logic [7:0] ENTRY_IO_APIC    = 8'd1;
   localparam logic [7:0] ENTRY_OVERRIDE   = 8'd2;
   localparam logic [7:0] ENTRY_LAPIC_ADDR = 8'd5;

   typedef enum logic [2:0] {
      KIND_PROCESSOR  = 3'd0,
      KIND_IO_APIC    = 3'd1,
      KIND_OVERRIDE   = 3'd2,
      KIND_LOCAL_ADDR = 3'd3,
      KIND_SUMMARY    = 3'd4
   } record_kind_type;

   typedef struct packed {
      logic [7:0] table_byte;
      logic       table_start;
   } req_type;

   typedef struct packed {
      record_kind_type       record_kind;
      logic [7:0]            processor_index;
      logic [7:0]            first_id;
      logic [7:0]            second_id;
      logic [31:0]           value_word;
      logic [31:0]           second_value;
      logic                  signature_good;
      logic                  checksum_good;
      logic                  malformed;
      logic [COUNT_BITS-1:0] processor_count;
      logic                  last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } head_type;

   function automatic logic [7:0] sig_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0: c = 8'h41;
         2'd1: c = 8'h50;
         2'd2: c = 8'h49;
         default: c = 8'h43;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/amsp_front.sv @@
`default_nettype none
module amsp_front #(
   parameter int MAX_PROCESSORS = amsp_pkg::MAX_PROCESSORS_DEFAULT,
   parameter int POSITION_BITS  = amsp_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire amsp_pkg::req_type req,
   input  wire logic              queue_room,
   output amsp_pkg::push_type     push
);

   localparam int PB = POSITION_BITS;
   localparam logic [32:0] POS_LIMIT = (33'd1 << POSITION_BITS) - 33'd1;
   localparam int CB = amsp_pkg::COUNT_BITS;

   logic [PB-1:0] pos_ff, pos_cur, pos_in;
   logic [31:0]   len_ff, len_cur, len_in;
   logic [7:0]    sum_ff, sum_cur, sum_in;
   logic          sig_ff, sig_cur, sig_in;
   logic [7:0]    eoff_ff, eoff_cur, eoff_in;
   logic [7:0]    etype_ff, etype_cur, etype_in;
   logic [7:0]    elen_ff, elen_cur, elen_in;
   logic [15:0]   ids_ff, ids_cur, ids_in;
   logic [31:0]   val_ff, val_cur, val_in;
   logic [31:0]   laddr_ff, laddr_cur, laddr_in;
   logic [31:0]   ioaddr_ff, ioaddr_cur, ioaddr_in;
   logic          io_seen_ff, io_seen_cur, io_seen_in;
   logic [CB-1:0] cpu_ff, cpu_cur, cpu_in;
   logic          bad_ff, bad_cur, bad_in;

   logic [7:0]    b;
   logic          accept;
   logic [PB-1:0] end_pos;
   logic          ignore;
   logic          walk;
   logic          finish_chk;
   logic          rec_valid;
   logic          sum_valid;
   amsp_pkg::rsp_type rec;
   amsp_pkg::rsp_type summ;

   assign b         = req.table_byte;
   assign req_ready = queue_room;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (req.table_start) begin
         pos_cur     = '0;
         len_cur     = '0;
         sum_cur     = '0;
         sig_cur     = 1'b1;
         eoff_cur    = '0;
         etype_cur   = '0;
         elen_cur    = '0;
         ids_cur     = '0;
         val_cur     = '0;
         laddr_cur   = '0;
         ioaddr_cur  = '0;
         io_seen_cur = 1'b0;
         cpu_cur     = '0;
         bad_cur     = 1'b0;
      end else begin
         pos_cur     = pos_ff;
         len_cur     = len_ff;
         sum_cur     = sum_ff;
         sig_cur     = sig_ff;
         eoff_cur    = eoff_ff;
         etype_cur   = etype_ff;
         elen_cur    = elen_ff;
         ids_cur     = ids_ff;
         val_cur     = val_ff;
         laddr_cur   = laddr_ff;
         ioaddr_cur  = ioaddr_ff;
         io_seen_cur = io_seen_ff;
         cpu_cur     = cpu_ff;
         bad_cur     = bad_ff;
      end
   end

   always_comb begin
      len_in = len_cur;
      if (pos_cur >= PB'(4) && pos_cur < PB'(8)) begin
         len_in = len_cur | ({24'd0, b} << {pos_cur[1:0], 3'b000});
      end
      if ({1'b0, len_in} > POS_LIMIT) begin
         end_pos = '1;
      end else if (len_in < 32'd8) begin
         end_pos = PB'(8);
      end else begin
         end_pos = len_in[PB-1:0];
      end
   end

   assign ignore = (pos_cur >= PB'(8)) && (pos_cur >= end_pos);
   assign pos_in = pos_cur + PB'(1);
   assign sum_in = sum_cur + b;
   assign sig_in = sig_cur && !(pos_cur < PB'(4) && b != amsp_pkg::sig_char(pos_cur[1:0]));
   assign walk   = (pos_cur >= PB'(amsp_pkg::HEADER_BYTES)) && !bad_cur;

   always_comb begin
      bad_in     = bad_cur;
      laddr_in   = laddr_cur;
      eoff_in    = eoff_cur;
      etype_in   = etype_cur;
      elen_in    = elen_cur;
      ids_in     = ids_cur;
      val_in     = val_cur;
      ioaddr_in  = ioaddr_cur;
      io_seen_in = io_seen_cur;
      cpu_in     = cpu_cur;
      finish_chk = 1'b0;
      rec_valid  = 1'b0;
      rec        = '0;

      if (pos_cur == PB'(7) &&
          (len_in < 32'(amsp_pkg::HEADER_BYTES) || {1'b0, len_in} > POS_LIMIT)) begin
         bad_in = 1'b1;
      end
      if (pos_cur >= PB'(36) && pos_cur < PB'(40)) begin
         laddr_in = laddr_cur | ({24'd0, b} << {pos_cur[1:0], 3'b000});
      end

      if (walk) begin
         if (eoff_cur == 8'd0) begin
            etype_in = b;
            ids_in   = '0;
            val_in   = '0;
            eoff_in  = 8'd1;
         end else begin
            finish_chk = 1'b1;
            if (eoff_cur == 8'd1) begin
               elen_in = b;
               if (b < 8'd2) begin
                  bad_in     = 1'b1;
                  finish_chk = 1'b0;
               end
            end else if (eoff_cur == 8'd2) begin
               ids_in[7:0] = b;
            end else if (eoff_cur == 8'd3) begin
               ids_in[15:8] = b;
            end else if (eoff_cur < 8'd8) begin
               val_in = val_cur | ({24'd0, b} << {eoff_cur[1:0], 3'b000});
            end

            if (finish_chk) begin
               if ({1'b0, eoff_cur} + 9'd1 < {1'b0, elen_in}) begin
                  eoff_in = eoff_cur + 8'd1;
               end else begin
                  eoff_in = 8'd0;
                  unique case (etype_cur)
                     amsp_pkg::ENTRY_PROCESSOR: begin
                        if (cpu_cur < CB'(MAX_PROCESSORS)) begin
                           rec_valid           = 1'b1;
                           rec.record_kind     = amsp_pkg::KIND_PROCESSOR;
                           rec.processor_index = cpu_cur[7:0];
                           rec.first_id        = ids_in[7:0];
                           rec.second_id       = ids_in[15:8];
                        end
                        if (cpu_cur < amsp_pkg::COUNT_SAT) begin
                           cpu_in = cpu_cur + CB'(1);
                        end
                     end
                     amsp_pkg::ENTRY_IO_APIC: begin
                        if (!io_seen_cur) begin
                           ioaddr_in       = val_in;
                           io_seen_in      = (val_in != 32'd0);
                           rec_valid       = 1'b1;
                           rec.record_kind = amsp_pkg::KIND_IO_APIC;
                           rec.value_word  = val_in;
                        end
                     end
                     amsp_pkg::ENTRY_OVERRIDE: begin
                        rec_valid       = 1'b1;
                        rec.record_kind = amsp_pkg::KIND_OVERRIDE;
                        rec.first_id    = ids_in[15:8];
                        rec.value_word  = val_in;
                     end
                     amsp_pkg::ENTRY_LAPIC_ADDR: begin
                        laddr_in        = val_in;
                        rec_valid       = 1'b1;
                        rec.record_kind = amsp_pkg::KIND_LOCAL_ADDR;
                        rec.value_word  = val_in;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
      end
   end

   always_comb begin
      sum_valid = (pos_cur >= PB'(7)) && ({1'b0, pos_cur} + (PB+1)'(1) == {1'b0, end_pos});
      summ                 = '0;
      summ.record_kind     = amsp_pkg::KIND_SUMMARY;
      summ.value_word      = laddr_in;
      summ.second_value    = ioaddr_in;
      summ.signature_good  = sig_in;
      summ.checksum_good   = (sum_in == 8'd0);
      summ.malformed       = bad_in;
      summ.processor_count = cpu_in;
      summ.last_of_run     = 1'b1;
   end

   always_comb begin
      push = '0;
      if (accept && !ignore) begin
         if (rec_valid && sum_valid) begin
            push.count  = 2'd2;
            push.first  = rec;
            push.second = summ;
         end else if (rec_valid) begin
            push.count             = 2'd1;
            push.first             = rec;
            push.first.last_of_run = 1'b1;
         end else if (sum_valid) begin
            push.count = 2'd1;
            push.first = summ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         len_ff     <= '0;
         sum_ff     <= '0;
         sig_ff     <= 1'b1;
         eoff_ff    <= '0;
         etype_ff   <= '0;
         elen_ff    <= '0;
         ids_ff     <= '0;
         val_ff     <= '0;
         laddr_ff   <= '0;
         ioaddr_ff  <= '0;
         io_seen_ff <= 1'b0;
         cpu_ff     <= '0;
         bad_ff     <= 1'b0;
      end else if (accept && !ignore) begin
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         sum_ff     <= sum_in;
         sig_ff     <= sig_in;
         eoff_ff    <= eoff_in;
         etype_ff   <= etype_in;
         elen_ff    <= elen_in;
         ids_ff     <= ids_in;
         val_ff     <= val_in;
         laddr_ff   <= laddr_in;
         ioaddr_ff  <= ioaddr_in;
         io_seen_ff <= io_seen_in;
         cpu_ff     <= cpu_in;
         bad_ff     <= bad_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/amsp_queue.sv @@
`default_nettype none
module amsp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire amsp_pkg::push_type push,
   output logic                    room,
   output amsp_pkg::head_type      head,
   input  wire logic               pop
);

   localparam int PW = amsp_pkg::Q_PTR_BITS;

   amsp_pkg::rsp_type slots_ff [amsp_pkg::Q_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic [PW-1:0] wr_next;

   assign wr_next   = wr_ptr_ff + PW'(1);
   assign room      = count_ff <= (PW+1)'(amsp_pkg::Q_DEPTH - 2);
   assign head.valid = count_ff != '0;
   assign head.data  = slots_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + (PW+1)'(push.count) - (PW+1)'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slots_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slots_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/amsp_back.sv @@
`default_nettype none
module amsp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire amsp_pkg::head_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output amsp_pkg::rsp_type       rsp
);

   logic              rsp_valid_ff, rsp_valid_in;
   amsp_pkg::rsp_type rsp_ff;

   assign pop          = head.valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp          = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= head.data;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/acpi_madt_stream_parser.sv @@
// An accepted byte's records are written into the queue, then moved into the output register.
// Throughput: one byte per cycle; the table's last byte may push two records into
// a four-entry queue, drained one record per cycle by the output register while
// rsp_ready is high. The front stalls only while fewer than two queue slots are free.
// Reset: synchronous, active high; clears the parse state and empties the queue.
`default_nettype none
module acpi_madt_stream_parser #(
   parameter int MAX_PROCESSORS = amsp_pkg::MAX_PROCESSORS_DEFAULT,
   parameter int POSITION_BITS  = amsp_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire amsp_pkg::req_type req,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output amsp_pkg::rsp_type      rsp
);

   amsp_pkg::push_type push;
   amsp_pkg::head_type head;
   logic               room;
   logic               pop;

   amsp_front #(
      .MAX_PROCESSORS (MAX_PROCESSORS),
      .POSITION_BITS  (POSITION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .queue_room (room),
      .push       (push)
   );

   amsp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .head  (head),
      .pop   (pop)
   );

   amsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule
`default_nettype wire

@@ hw/rtl/amsp_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module amsp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire amsp_pkg::req_type req,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire amsp_pkg::rsp_type rsp
);

   `ASSERT_CLK_ANY(a_idle_after_reset, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `ASSERT_CLK(a_req_hold, clock, reset,
      req_valid && !req_ready |=> req_valid && $stable(req), "waiting transaction changed")

   `ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "stalled transaction changed")

   `ASSERT_CLK(a_summary_last, clock, reset,
      rsp_valid && rsp.record_kind == amsp_pkg::KIND_SUMMARY |-> rsp.last_of_run,
      "summary not last of run")

   `ASSERT_CLK(a_entry_clean, clock, reset,
      rsp_valid && rsp.record_kind != amsp_pkg::KIND_SUMMARY |->
         rsp.second_value == 32'd0 && !rsp.signature_good && !rsp.checksum_good &&
         !rsp.malformed && rsp.processor_count == '0,
      "entry record carries summary fields")

endmodule

bind acpi_madt_stream_parser amsp_checker u_amsp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);
`default_nettype wire
